FILE: rtl/sicfs_pkg.sv
// Shared types, register indexes and helper functions for the section import block.
`timescale 1ns / 1ps
package sicfs_pkg;

	// Destination frame defaults
	localparam int DstWidthDefault  = 2048;
	localparam int DstHeightDefault = 2048;

	// Configuration port geometry
	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 32;

	// Register indexes
	localparam logic [CfgIndexW-1:0] REG_SEC_X_FIRST = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_SEC_X_LAST  = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_SEC_Y_FIRST = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_SEC_Y_LAST  = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_DST_X_START = 3'd4;
	localparam logic [CfgIndexW-1:0] REG_DST_Y_START = 3'd5;
	localparam logic [CfgIndexW-1:0] REG_FLIP_MODE   = 3'd6;
	localparam logic [CfgIndexW-1:0] REG_VALUE_SCALE = 3'd7;

	// Input item
	typedef struct packed {
		logic        [11:0] src_x;
		logic        [11:0] src_y;
		logic signed [31:0] pixel_value;
	} in_t;

	// Result item
	typedef struct packed {
		logic        [11:0] dst_x;
		logic        [11:0] dst_y;
		logic signed [31:0] scaled_value;
	} out_t;

	// Configuration register set
	typedef struct packed {
		logic signed [13:0] sec_x_first;
		logic signed [13:0] sec_x_last;
		logic signed [13:0] sec_y_first;
		logic signed [13:0] sec_y_last;
		logic signed [14:0] dst_x_start;
		logic signed [14:0] dst_y_start;
		logic        [1:0]  flip_mode;
		logic signed [31:0] value_scale;
	} cfg_t;

	// Floor shift by 16 of a Q16.16 product, saturated to 32 bits
	function automatic logic signed [31:0] scale_sat(input logic signed [63:0] prod);
		logic [16:0] hi;
		logic signed [31:0] res;
		hi = prod[63:47];
		if (hi == '0 || hi == '1)
			res = prod[47:16];
		else if (prod[63])
			res = 32'sh8000_0000;
		else
			res = 32'sh7fff_ffff;
		return res;
	endfunction

endpackage

FILE: rtl/sicfs_cfg.sv
// Configuration register file for the section import block.
`timescale 1ns / 1ps
module sicfs_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sicfs_pkg::CfgIndexW-1:0]   cfg_index,
	input  logic [sicfs_pkg::CfgDataW-1:0]    cfg_data,
	output sicfs_pkg::cfg_t                   cfg
);

	sicfs_pkg::cfg_t cfg_q;

	// Register writes, low bits of the data kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sec_x_first <= 14'sd0;
			cfg_q.sec_x_last  <= 14'sd4096;
			cfg_q.sec_y_first <= 14'sd0;
			cfg_q.sec_y_last  <= 14'sd4096;
			cfg_q.dst_x_start <= 15'sd1;
			cfg_q.dst_y_start <= 15'sd1;
			cfg_q.flip_mode   <= 2'd0;
			cfg_q.value_scale <= 32'sd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sicfs_pkg::REG_SEC_X_FIRST: cfg_q.sec_x_first <= cfg_data[13:0];
				sicfs_pkg::REG_SEC_X_LAST:  cfg_q.sec_x_last  <= cfg_data[13:0];
				sicfs_pkg::REG_SEC_Y_FIRST: cfg_q.sec_y_first <= cfg_data[13:0];
				sicfs_pkg::REG_SEC_Y_LAST:  cfg_q.sec_y_last  <= cfg_data[13:0];
				sicfs_pkg::REG_DST_X_START: cfg_q.dst_x_start <= cfg_data[14:0];
				sicfs_pkg::REG_DST_Y_START: cfg_q.dst_y_start <= cfg_data[14:0];
				sicfs_pkg::REG_FLIP_MODE:   cfg_q.flip_mode   <= cfg_data[1:0];
				sicfs_pkg::REG_VALUE_SCALE: cfg_q.value_scale <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/sicfs_axis.sv
// One axis of the coordinate map: section test, flip, offset and frame test.
`timescale 1ns / 1ps
module sicfs_axis #(
	parameter int LIMIT = sicfs_pkg::DstWidthDefault
) (
	input  logic [11:0]        src,
	input  logic signed [13:0] first,
	input  logic signed [13:0] last,
	input  logic signed [14:0] start,
	input  logic               flip,
	output logic               keep,
	output logic [11:0]        coord
);

	localparam logic signed [16:0] Lim = 17'(LIMIT);

	logic signed [13:0] src_w;
	logic signed [14:0] off;
	logic signed [16:0] off_w;
	logic signed [16:0] d;
	logic               in_sec;

	// Section bounds: first inclusive, last exclusive
	assign src_w  = $signed({2'b00, src});
	assign in_sec = (src_w >= first) && (src_w < last);

	// Offset from the first section line, negated on a flipped axis
	assign off   = $signed({3'b000, src}) - $signed({first[13], first});
	assign off_w = $signed({{2{off[14]}}, off});
	assign d     = $signed({{2{start[14]}}, start}) - 17'sd1 + (flip ? -off_w : off_w);

	assign keep  = in_sec && (d >= 17'sd0) && (d < Lim);
	assign coord = d[11:0];

endmodule

FILE: rtl/section_import_clip_flip_scale.sv
// Top level of the section import block: input register, map and multiply, result register.
// Copies one source pixel per clock into a destination frame: a pixel inside the configured
// section is mapped per axis to start - 1 + offset (offset negated on a flipped axis), dropped
// unless it lands inside the DST_WIDTH x DST_HEIGHT frame, and its value is scaled by a signed
// Q16.16 factor, floored and saturated to 32 bits. The block takes one item per clock and a
// kept pixel passes from the input register, which loads at the edge that accepts it, through
// the product register to the result register, where it is presented; the input stalls only
// while the result register is held and both earlier stages are full. The 32 x 32 multiply
// sits beside the coordinate map between the input and product registers. Dropped pixels produce
// no result. Registers must be written only while no item is in flight; the block does not enforce it.
`timescale 1ns / 1ps
module section_import_clip_flip_scale #(
	parameter int DST_WIDTH  = sicfs_pkg::DstWidthDefault,
	parameter int DST_HEIGHT = sicfs_pkg::DstHeightDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  sicfs_pkg::in_t                   in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output sicfs_pkg::out_t                  out_item,
	input  logic                             cfg_we,
	input  logic [sicfs_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [sicfs_pkg::CfgDataW-1:0]   cfg_data
);

	sicfs_pkg::cfg_t    cfg;
	sicfs_pkg::in_t     item_s1;
	logic               valid_s1;
	logic               valid_s2;
	logic [11:0]        dx_s2;
	logic [11:0]        dy_s2;
	logic signed [63:0] prod_s2;
	logic               out_valid_q;
	sicfs_pkg::out_t    out_item_q;

	logic               keep_x;
	logic               keep_y;
	logic [11:0]        dx;
	logic [11:0]        dy;
	logic               adv_out;
	logic               adv_s2;

	sicfs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sicfs_axis #(.LIMIT(DST_WIDTH)) u_axis_x (
		.src   (item_s1.src_x),
		.first (cfg.sec_x_first),
		.last  (cfg.sec_x_last),
		.start (cfg.dst_x_start),
		.flip  (cfg.flip_mode[0]),
		.keep  (keep_x),
		.coord (dx)
	);

	sicfs_axis #(.LIMIT(DST_HEIGHT)) u_axis_y (
		.src   (item_s1.src_y),
		.first (cfg.sec_y_first),
		.last  (cfg.sec_y_last),
		.start (cfg.dst_y_start),
		.flip  (cfg.flip_mode[1]),
		.keep  (keep_y),
		.coord (dy)
	);

	// Pipeline flow: a stage loads when the next one is empty or moving on
	assign adv_out  = !out_valid_q || out_ready;
	assign adv_s2   = !valid_s2 || adv_out;
	assign in_ready = !valid_s1 || adv_s2;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1 && keep_x && keep_y;
			if (adv_out)
				out_valid_q <= valid_s2;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_item;
	end

	// Mapped coordinates and product
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			dx_s2   <= dx;
			dy_s2   <= dy;
			prod_s2 <= item_s1.pixel_value * cfg.value_scale;
		end
	end

	// Result register: floor shift and saturation
	always_ff @(posedge clk) begin
		if (adv_out && valid_s2) begin
			out_item_q.dst_x        <= dx_s2;
			out_item_q.dst_y        <= dy_s2;
			out_item_q.scaled_value <= sicfs_pkg::scale_sat(prod_s2);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

FILE: tb/section_import_clip_flip_scale_tb.sv
// Self-checking testbench for the section import block: clipped, flipped and scaled pixel copy.
`timescale 1ns / 1ps
module section_import_clip_flip_scale_tb;

	localparam int  DstW        = 2048;
	localparam int  DstH        = 2048;
	localparam int  DrainCycles = 12;
	localparam int  HoldCycles  = 300;
	localparam int  CycleLimit  = 400000;
	localparam int  RandPhases  = 16;
	localparam int  PhaseItems  = 100;
	localparam longint SatMax   = 64'sh0000_0000_7fff_ffff;
	localparam longint SatMin   = -SatMax - 1;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_ready;
	sicfs_pkg::in_t                  in_item   = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	sicfs_pkg::out_t                 out_item;
	logic                            cfg_we    = 1'b0;
	logic [sicfs_pkg::CfgIndexW-1:0] cfg_index = '0;
	logic [sicfs_pkg::CfgDataW-1:0]  cfg_data  = '0;

	// Testbench copy of the register file, updated as each write is issued
	sicfs_pkg::cfg_t cfg_model;

	sicfs_pkg::in_t  pixel_backlog[$];
	sicfs_pkg::out_t due_pixels[$];

	bit  send_idle_on = 1'b1;
	bit  recv_idle_on = 1'b1;
	bit  hold_req     = 1'b0;
	bit  hold_armed;
	int  hold_left;
	int  send_gap;
	int  recv_stall;
	int  cycle_count  = 0;
	int  n_sent       = 0;
	int  n_copied     = 0;
	int  n_dropped    = 0;
	int  n_checked    = 0;
	int  n_mism       = 0;
	int  n_settings   = 0;

	section_import_clip_flip_scale #(
		.DST_WIDTH (DstW),
		.DST_HEIGHT(DstH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Map one source pixel into the destination frame; returns 1 when a result is due
	function automatic bit map_pixel(input sicfs_pkg::in_t px, input sicfs_pkg::cfg_t c,
		output sicfs_pkg::out_t res);
		longint col, row, x_off, y_off, dx, dy, prod, q;
		col   = longint'(px.src_x);
		row   = longint'(px.src_y);
		res   = '0;
		if (col < longint'($signed(c.sec_x_first)) || col >= longint'($signed(c.sec_x_last)) ||
		    row < longint'($signed(c.sec_y_first)) || row >= longint'($signed(c.sec_y_last)))
			return 1'b0;
		x_off = col - longint'($signed(c.sec_x_first));
		y_off = row - longint'($signed(c.sec_y_first));
		dx    = longint'($signed(c.dst_x_start)) - 1 + (c.flip_mode[0] ? -x_off : x_off);
		dy    = longint'($signed(c.dst_y_start)) - 1 + (c.flip_mode[1] ? -y_off : y_off);
		if (dx < 0 || dx >= DstW || dy < 0 || dy >= DstH)
			return 1'b0;
		// floor of the Q16.16 product, then clamp to 32 bits
		prod = longint'($signed(px.pixel_value)) * longint'($signed(c.value_scale));
		q    = prod >>> 16;
		if (q > SatMax)
			q = SatMax;
		else if (q < SatMin)
			q = SatMin;
		res.dst_x        = dx[11:0];
		res.dst_y        = dy[11:0];
		res.scaled_value = q[31:0];
		return 1'b1;
	endfunction

	// Sender: offers queued items, random gap after each accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				sicfs_pkg::out_t res;
				n_sent++;
				if (map_pixel(in_item, cfg_model, res)) begin
					due_pixels.push_back(res);
					n_copied++;
				end else
					n_dropped++;
				send_gap = send_idle_on ? $urandom_range(0, 15) : 0;
			end
			if (!in_valid || in_ready) begin
				if (send_gap == 0 && pixel_backlog.size() != 0) begin
					in_item  <= pixel_backlog.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
					if (send_gap != 0)
						send_gap--;
				end
			end
		end
	end

	// Long receiver hold-off, started on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_armed <= 1'b0;
		end else if (hold_req && !hold_armed) begin
			hold_left  <= HoldCycles;
			hold_armed <= 1'b1;
		end else begin
			if (hold_left != 0)
				hold_left <= hold_left - 1;
			if (!hold_req)
				hold_armed <= 1'b0;
		end
	end

	// Receiver: checks each result against the oldest expectation, stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				sicfs_pkg::out_t exp_px;
				n_checked++;
				if (due_pixels.size() == 0) begin
					n_mism++;
					if (n_mism <= 10)
						$display("cycle %0d: result with nothing pending: x=%0d y=%0d v=%0d",
							cycle_count, out_item.dst_x, out_item.dst_y, out_item.scaled_value);
				end else begin
					exp_px = due_pixels.pop_front();
					if (out_item.dst_x !== exp_px.dst_x || out_item.dst_y !== exp_px.dst_y ||
					    out_item.scaled_value !== exp_px.scaled_value) begin
						n_mism++;
						if (n_mism <= 10)
							$display("cycle %0d: mismatch: exp x=%0d y=%0d v=%0d, got x=%0d y=%0d v=%0d",
								cycle_count, exp_px.dst_x, exp_px.dst_y, exp_px.scaled_value,
								out_item.dst_x, out_item.dst_y, out_item.scaled_value);
					end
				end
				recv_stall = recv_idle_on ? $urandom_range(0, 15) : 0;
			end else if (recv_stall != 0)
				recv_stall--;
			out_ready <= (recv_stall == 0) && (hold_left == 0);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				due_pixels.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// One register write; upper bits of the data bus carry junk
	task automatic put_reg(input logic [sicfs_pkg::CfgIndexW-1:0] idx, input int val);
		logic [31:0] junk;
		logic [31:0] data;
		junk = $urandom;
		data = val;
		case (idx)
			sicfs_pkg::REG_SEC_X_FIRST: begin
				data = {junk[31:14], data[13:0]};
				cfg_model.sec_x_first = data[13:0];
			end
			sicfs_pkg::REG_SEC_X_LAST: begin
				data = {junk[31:14], data[13:0]};
				cfg_model.sec_x_last = data[13:0];
			end
			sicfs_pkg::REG_SEC_Y_FIRST: begin
				data = {junk[31:14], data[13:0]};
				cfg_model.sec_y_first = data[13:0];
			end
			sicfs_pkg::REG_SEC_Y_LAST: begin
				data = {junk[31:14], data[13:0]};
				cfg_model.sec_y_last = data[13:0];
			end
			sicfs_pkg::REG_DST_X_START: begin
				data = {junk[31:15], data[14:0]};
				cfg_model.dst_x_start = data[14:0];
			end
			sicfs_pkg::REG_DST_Y_START: begin
				data = {junk[31:15], data[14:0]};
				cfg_model.dst_y_start = data[14:0];
			end
			sicfs_pkg::REG_FLIP_MODE: begin
				data = {junk[31:2], data[1:0]};
				cfg_model.flip_mode = data[1:0];
			end
			sicfs_pkg::REG_VALUE_SCALE: cfg_model.value_scale = data;
			default: ;
		endcase
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Full register set, written while the block is idle
	task automatic set_all(input int xf, input int xl, input int yf, input int yl,
		input int xs, input int ys, input int fl, input int sc);
		@(posedge clk);
		put_reg(sicfs_pkg::REG_SEC_X_FIRST, xf);
		put_reg(sicfs_pkg::REG_SEC_X_LAST, xl);
		put_reg(sicfs_pkg::REG_SEC_Y_FIRST, yf);
		put_reg(sicfs_pkg::REG_SEC_Y_LAST, yl);
		put_reg(sicfs_pkg::REG_DST_X_START, xs);
		put_reg(sicfs_pkg::REG_DST_Y_START, ys);
		put_reg(sicfs_pkg::REG_FLIP_MODE, fl);
		put_reg(sicfs_pkg::REG_VALUE_SCALE, sc);
		cfg_we <= 1'b0;
		@(negedge clk);
		n_settings++;
	endtask

	task automatic queue_pixel(input int x, input int y, input int v);
		sicfs_pkg::in_t px;
		px.src_x       = x[11:0];
		px.src_y       = y[11:0];
		px.pixel_value = v;
		pixel_backlog.push_back(px);
	endtask

	// Wait until every item has gone in and every result is out, then let the pipe empty
	task automatic settle();
		do
			@(negedge clk);
		while (pixel_backlog.size() != 0 || in_valid || due_pixels.size() != 0);
		repeat (DrainCycles) @(negedge clk);
	endtask

	initial begin
		int xf, xl, yf, yl, xs, ys, fl, sc;
		int lo_x, hi_x, lo_y, hi_y, t, x, y, v;

		// register file after reset
		cfg_model.sec_x_first = 14'sd0;
		cfg_model.sec_x_last  = 14'sd4096;
		cfg_model.sec_y_first = 14'sd0;
		cfg_model.sec_y_last  = 14'sd4096;
		cfg_model.dst_x_start = 15'sd1;
		cfg_model.dst_y_start = 15'sd1;
		cfg_model.flip_mode   = 2'd0;
		cfg_model.value_scale = 32'sd65536;

		repeat (10) @(posedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: frame edges and value extremes at unit scale
		queue_pixel(0, 0, 1);
		queue_pixel(2047, 2047, 32'h7fff_ffff);
		queue_pixel(2048, 5, 7);
		queue_pixel(5, 2048, 7);
		queue_pixel(4095, 4095, 32'h8000_0000);
		queue_pixel(1, 2, -1);
		queue_pixel(3, 4, 32'h8000_0000);
		settle();

		// both axes flipped, most negative scale: saturation both ways, section edges
		set_all(10, 20, 100, 110, 30, 20, 3, 32'h8000_0000);
		queue_pixel(10, 100, 32'h8000_0000);
		queue_pixel(19, 109, 32'h7fff_ffff);
		queue_pixel(9, 100, 1);
		queue_pixel(20, 100, 1);
		queue_pixel(10, 99, 1);
		queue_pixel(10, 110, 1);
		queue_pixel(15, 105, -1);
		settle();

		// widest section, extreme starts, column flip, largest scale
		set_all(-4096, 4096, -4096, 4096, 8192, -4095, 1, 32'h7fff_ffff);
		queue_pixel(2048, 0, 1);
		queue_pixel(2047, 0, 1);
		queue_pixel(4095, 2047, -1);
		queue_pixel(4095, 2048, 5);
		settle();

		// empty section, then inverted section: nothing comes out
		set_all(100, 100, 0, 4096, 1, 1, 0, 65536);
		queue_pixel(100, 100, 3);
		queue_pixel(99, 100, 3);
		queue_pixel(101, 100, 3);
		settle();
		set_all(0, 4096, 200, 50, 1, 1, 2, 65536);
		queue_pixel(10, 50, 3);
		queue_pixel(10, 150, 3);
		settle();

		// random settings, mostly pixels near the section with random content
		for (int ph = 0; ph < RandPhases; ph++) begin
			t = $urandom_range(0, 7);
			if (t == 0) begin
				xf = -4096;
				xl = 4096;
			end else begin
				xf = int'($urandom_range(0, 4200)) - 100;
				xl = (t == 1) ? xf - int'($urandom_range(0, 50)) : xf + int'($urandom_range(1, 400));
			end
			t = $urandom_range(0, 7);
			if (t == 0) begin
				yf = -4096;
				yl = 4096;
			end else begin
				yf = int'($urandom_range(0, 4200)) - 100;
				yl = (t == 1) ? yf - int'($urandom_range(0, 50)) : yf + int'($urandom_range(1, 400));
			end
			xf = (xf > 4096) ? 4096 : xf;
			xl = (xl > 4096) ? 4096 : ((xl < -4096) ? -4096 : xl);
			yf = (yf > 4096) ? 4096 : yf;
			yl = (yl > 4096) ? 4096 : ((yl < -4096) ? -4096 : yl);
			xs = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8192 : -8192)
				: int'($urandom_range(0, 2600)) - 300;
			ys = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8192 : -8192)
				: int'($urandom_range(0, 2600)) - 300;
			// hold-off phase: section covers the frame so most pixels come out and the pipe fills
			if (ph == 7) begin
				xf = 0;
				xl = DstW;
				yf = 0;
				yl = DstH;
				xs = 1;
				ys = 1;
			end
			fl = $urandom_range(0, 3);
			case ($urandom_range(0, 6))
				0: sc = 65536;
				1: sc = -65536;
				2: sc = 32'h8000_0000;
				3: sc = 32'h7fff_ffff;
				4: sc = 0;
				5: sc = int'($urandom_range(0, 1 << 20)) - (1 << 19);
				default: sc = $urandom;
			endcase
			set_all(xf, xl, yf, yl, xs, ys, fl, sc);

			// phase 3 streams flat out, phase 7 runs into a long receiver hold-off with the sender flat out
			send_idle_on = (ph == 3 || ph == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
			recv_idle_on = (ph == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
			hold_req     = (ph == 7);

			lo_x = (xf < xl ? xf : xl) - 2;
			hi_x = (xf < xl ? xl : xf) + 1;
			lo_y = (yf < yl ? yf : yl) - 2;
			hi_y = (yf < yl ? yl : yf) + 1;
			lo_x = (lo_x < 0) ? 0 : ((lo_x > 4095) ? 4095 : lo_x);
			hi_x = (hi_x < lo_x) ? lo_x : ((hi_x > 4095) ? 4095 : hi_x);
			lo_y = (lo_y < 0) ? 0 : ((lo_y > 4095) ? 4095 : lo_y);
			hi_y = (hi_y < lo_y) ? lo_y : ((hi_y > 4095) ? 4095 : hi_y);
			for (int k = 0; k < PhaseItems; k++) begin
				case ($urandom_range(0, 5))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = int'($urandom_range(0, 2000)) - 1000;
					default: v = $urandom;
				endcase
				if ($urandom_range(0, 9) < 8) begin
					x = $urandom_range(lo_x, hi_x);
					y = $urandom_range(lo_y, hi_y);
				end else begin
					x = $urandom_range(0, 4095);
					y = $urandom_range(0, 4095);
				end
				queue_pixel(x, y, v);
			end
			settle();
			hold_req = 1'b0;

			// sender pause mid-setting: drain, then carry on with the same registers
			if (ph == 10) begin
				for (int k = 0; k < 20; k++)
					queue_pixel($urandom_range(lo_x, hi_x), $urandom_range(lo_y, hi_y), $urandom);
				settle();
			end
		end

		settle();
		$display("covered %0d pixels under %0d register settings: %0d copied, %0d dropped",
			n_sent, n_settings, n_copied, n_dropped);
		$display("%0d results checked, %0d mismatches, %0d cycles", n_checked, n_mism,
			cycle_count);
		if (n_mism == 0 && due_pixels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
